// ===== hw/rtl/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg
// Shared widths, link types and the window length rule for the sliding median
// filter.
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int MAX_WINDOW = 15;
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 4;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W      = $clog2(MAX_WINDOW);

	localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = LEN_W'(5);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	// toward the upper neighbor: the cell's value once the oldest entry is removed
	typedef struct packed {
		sample_t b_val;
		cnt_t    b_age;
		logic    gtb;
		logic    above;
		logic    valid;
	} smf_up_t;

	// toward the lower neighbor: the cell's held entry
	typedef struct packed {
		sample_t val;
		cnt_t    age;
		logic    gt;
	} smf_dn_t;

	function automatic cnt_t effective_length(input logic [LEN_W-1:0] req);
		logic [CNT_W:0] len;
		len = (CNT_W + 1)'(req);
		if (len > (CNT_W + 1)'(MAX_WINDOW))
			len = (CNT_W + 1)'(MAX_WINDOW);
		if (len[0] == 1'b0) begin
			if (len + 1'b1 > (CNT_W + 1)'(MAX_WINDOW))
				len = len - 1'b1;
			else
				len = len + 1'b1;
		end
		if (len == '0)
			len = (CNT_W + 1)'(1);
		return len[CNT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/smf_cell.sv =====
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the sorted window: holds a sample and its age, drops it when it
// is the oldest, and shifts or takes the new sample to keep the row sorted.
// ----------------------------------------------------------------------------
module smf_cell
	import smf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    clear,
	input  logic    full,
	input  cnt_t    last_age,
	input  sample_t x,
	input  smf_up_t lo,
	input  smf_dn_t hi,
	output smf_up_t up,
	output smf_dn_t dn,
	output sample_t nxt_val
);

	sample_t val_q;
	cnt_t    age_q;
	logic    valid_q;

	logic    gt;
	logic    del;
	logic    above;
	sample_t b_val;
	cnt_t    b_age;
	logic    gtb;
	cnt_t    nxt_age;
	logic    nxt_valid;

	always_comb begin
		gt    = !valid_q || (val_q > x);
		del   = full && valid_q && (age_q == last_age);
		above = lo.above || del;
		b_val = above ? hi.val : val_q;
		b_age = above ? hi.age : age_q;
		gtb   = above ? hi.gt : gt;
		if (gtb) begin
			if (lo.gtb) begin
				nxt_val = lo.b_val;
				nxt_age = lo.b_age + 1'b1;
			end else begin
				nxt_val = x;
				nxt_age = '0;
			end
		end else begin
			nxt_val = b_val;
			nxt_age = b_age + 1'b1;
		end
		nxt_valid = full ? valid_q : (valid_q || lo.valid);
	end

	assign up = '{b_val: b_val, b_age: b_age, gtb: gtb, above: above, valid: valid_q};
	assign dn = '{val: val_q, age: age_q, gt: gt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !clear) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule

// ===== hw/rtl/sliding_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_median_filter_unit
// Median of the most recent samples over a configurable odd window, kept in a
// row of sorted cells that insert the new sample and drop the oldest.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  input     | in_valid / in_stall  | sample     (signed 16 bit)
//  output    | out_valid / out_stall| median     (signed 16 bit)
//  config    | window_len_we        | window_len (4 bit)
//
//  One transaction per cycle while the output is not stalled; the median
//  appears in the cycle after acceptance. The sorted cell row updates on
//  acceptance; a 15:1 select picks the middle cell into the output register.
//  Reset empties the window and sets the window length to 5.
//  A stalled result holds the output register and stalls the input.
// ----------------------------------------------------------------------------
module sliding_median_filter_unit
	import smf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             window_len_we,
	input  logic [LEN_W-1:0] window_len,
	input  logic             in_valid,
	output logic             in_stall,
	input  sample_t          sample,
	output logic             out_valid,
	input  logic             out_stall,
	output sample_t          median
);

	cnt_t    len_q;
	cnt_t    count_q;
	logic    out_valid_q;
	sample_t median_q;

	logic    advance;
	logic    full;
	cnt_t    last_age;
	cnt_t    n_next;
	cnt_t    mid;

	smf_up_t up_link [MAX_WINDOW];
	smf_dn_t dn_link [MAX_WINDOW];
	sample_t nxt_val [MAX_WINDOW];

	assign in_stall  = out_valid_q && out_stall;
	assign advance   = in_valid && !in_stall;
	assign full      = (count_q == len_q);
	assign last_age  = len_q - 1'b1;
	assign n_next    = full ? count_q : count_q + 1'b1;
	assign mid       = (n_next - 1'b1) >> 1;
	assign out_valid = out_valid_q;
	assign median    = median_q;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		smf_up_t lo;
		smf_dn_t hi;

		if (i == 0) begin : g_lo_edge
			assign lo = '{b_val: '0, b_age: '0, gtb: 1'b0, above: 1'b0, valid: 1'b1};
		end else begin : g_lo_link
			assign lo = up_link[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_hi_edge
			assign hi = '{val: '0, age: '0, gt: 1'b1};
		end else begin : g_hi_link
			assign hi = dn_link[i+1];
		end

		smf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.clear    (window_len_we),
			.full     (full),
			.last_age (last_age),
			.x        (sample),
			.lo       (lo),
			.hi       (hi),
			.up       (up_link[i]),
			.dn       (dn_link[i]),
			.nxt_val  (nxt_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= effective_length(WINDOW_LEN_RESET);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (window_len_we) begin
				len_q   <= effective_length(window_len);
				count_q <= '0;
			end else if (advance) begin
				count_q <= n_next;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			median_q <= nxt_val[mid[IDX_W-1:0]];
	end

endmodule

// ===== test/sliding_median_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_median_filter_unit_tb
// Drives signed samples through the median filter under random sender idling
// and receiver stalls, across a sweep of window lengths including the
// shortest and longest, and compares every median with a behavioral window
// model kept inside the bench, or with a fixed value for known probe rows.
// ----------------------------------------------------------------------------
module sliding_median_filter_unit_tb;
	import smf_pkg::*;

	typedef struct packed {
		sample_t value;
		logic    known;
		sample_t want;
	} probe_row_t;

	localparam int N_PROBES      = 20;
	localparam int N_PHASES      = 18;
	localparam int PHASE_SAMPLES = 80;
	localparam int MAX_REPORTS   = 10;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             window_len_we = 1'b0;
	logic [LEN_W-1:0] window_len    = '0;
	logic             in_valid      = 1'b0;
	logic             in_stall;
	sample_t          sample        = '0;
	logic             out_valid;
	logic             out_stall     = 1'b0;
	sample_t          median;

	int idle_pct  = 0;
	int stall_pct = 0;
	int fail_cnt  = 0;

	sample_t    pending_medians[$];
	sample_t    window_ring [MAX_WINDOW];
	cnt_t       win_eff = cnt_t'(5);
	cnt_t       wr_pos  = '0;
	cnt_t       held    = '0;

	probe_row_t probe_rows [N_PROBES] = '{
		'{16'sh7fff, 1'b1, 16'sh7fff},
		'{16'sh8000, 1'b1, 16'sh8000},
		'{16'sh0000, 1'b1, 16'sh0000},
		'{16'shffff, 1'b0, 16'sh0000},
		'{16'sh0001, 1'b1, 16'sh0000},
		'{16'sh8000, 1'b0, 16'sh0000},
		'{16'sh5555, 1'b0, 16'sh0000},
		'{16'shaaaa, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 16'sh0000},
		'{16'sh0064, 1'b0, 16'sh0000},
		'{16'shff9c, 1'b0, 16'sh0000},
		'{16'sh00ff, 1'b0, 16'sh0000},
		'{16'shff00, 1'b0, 16'sh0000},
		'{16'sh4000, 1'b0, 16'sh0000},
		'{16'shc000, 1'b0, 16'sh0000},
		'{16'sh7ffe, 1'b0, 16'sh0000},
		'{16'sh8001, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 16'sh0000}
	};

	logic [LEN_W-1:0] len_plan [16] = '{
		4'd0, 4'd15, 4'd14, 4'd1, 4'd2, 4'd7, 4'd8, 4'd9,
		4'd4, 4'd12, 4'd6, 4'd10, 4'd11, 4'd13, 4'd3, 4'd5
	};

	sliding_median_filter_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_len_we(window_len_we),
		.window_len   (window_len),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.median       (median)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// insert the sample into the window and return the (lower) middle value
	function automatic sample_t push_sample_median(input sample_t s);
		sample_t sorted [MAX_WINDOW];
		sample_t v;
		int      i;
		int      j;
		window_ring[wr_pos] = s;
		if (int'(wr_pos) + 1 >= int'(win_eff))
			wr_pos = '0;
		else
			wr_pos = wr_pos + 1'b1;
		if (held < win_eff)
			held = held + 1'b1;
		for (i = 0; i < int'(held); i++) begin
			v = window_ring[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		return sorted[(int'(held) - 1) / 2];
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: begin
				return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			end
			1, 2: begin
				return sample_t'(int'($urandom_range(0, 8)) - 4);
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	task automatic send_sample(input sample_t s, input logic known, input sample_t want);
		sample_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = push_sample_median(s);
		pending_medians.push_back(known ? want : predicted);
	endtask

	task automatic set_window_len(input logic [LEN_W-1:0] v);
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		window_len_we <= 1'b1;
		window_len    <= v;
		@(posedge clk);
		window_len_we <= 1'b0;
		// raise even lengths to odd; zero becomes one
		win_eff = cnt_t'({v[LEN_W-1:1], 1'b1});
		wr_pos  = '0;
		held    = '0;
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : median_check
		sample_t want;
		if (out_valid && !out_stall) begin
			if (pending_medians.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= MAX_REPORTS)
					$display("unexpected median transaction: %0d", median);
			end else begin
				want = pending_medians.pop_front();
				if (median !== want) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("median mismatch: expected %0d, got %0d", want, median);
				end
			end
		end
	end

	initial begin
		int k;
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct  = 25;
		stall_pct = 69;
		for (k = 0; k < N_PROBES; k++)
			send_sample(probe_rows[k].value, probe_rows[k].known, probe_rows[k].want);
		in_valid <= 1'b0;
		for (p = 0; p < N_PHASES; p++) begin
			if (p == 6) begin
				idle_pct  = 69;
				stall_pct = 25;
			end
			if (p == 12) begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			set_window_len(p < 16 ? len_plan[p] : LEN_W'($urandom));
			for (k = 0; k < PHASE_SAMPLES; k++)
				send_sample(pick_sample(), 1'b0, '0);
			in_valid <= 1'b0;
		end
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_medians.size() == 0 && fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
